>>> src/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Sizes, register indexes and shared types; used by every module in src.
package wbps_pkg;

   localparam int PATTERN_MAX  = 16;
   localparam int ADDRESS_BITS = 48;
   localparam int IDX_BITS     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_BITS     = $clog2(PATTERN_MAX + 1);
   localparam int SUM_BITS     = LEN_BITS + 1;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int REQ_DATA_BITS  = ((8 + ADDRESS_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((ADDRESS_BITS + 7) / 8) * 8;

   localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LEN  = 2'd2;

   typedef logic [7:0] byte_type;
   typedef byte_type [PATTERN_MAX-1:0] pattern_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

>>> src/wbps_cell.sv
// One window cell of the wildcard byte pattern scanner.
// Holds one window byte, shifts it toward the older neighbor, compares the
// byte it is about to take with its pattern byte. Depends on wbps_pkg.
module wbps_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  wbps_pkg::cell_ctl_type         ctl,
   input  logic [wbps_pkg::IDX_BITS-1:0]  cell_index,
   input  logic [wbps_pkg::LEN_BITS-1:0]  len,
   input  wbps_pkg::pattern_type          pattern,
   input  wbps_pkg::byte_type             byte_in,
   output wbps_pkg::byte_type             byte_out,
   output logic                           match_ok
);

   wbps_pkg::byte_type                   byte_ff;
   wbps_pkg::byte_type                   byte_in_next;
   logic [wbps_pkg::SUM_BITS-1:0]        k_sum;
   logic [wbps_pkg::SUM_BITS-1:0]        k_diff;
   logic                                 active;
   wbps_pkg::byte_type                   pat;

   always_comb begin
      k_sum  = wbps_pkg::SUM_BITS'(cell_index) + wbps_pkg::SUM_BITS'(len);
      k_diff = k_sum - wbps_pkg::SUM_BITS'(wbps_pkg::PATTERN_MAX);
      active = k_sum >= wbps_pkg::SUM_BITS'(wbps_pkg::PATTERN_MAX);
      pat    = pattern[k_diff[wbps_pkg::IDX_BITS-1:0]];
      match_ok = !active || (pat == wbps_pkg::WILDCARD_BYTE) || (pat == byte_in);
      byte_in_next = byte_ff;
      if (ctl.load) begin
         byte_in_next = ctl.clear ? 8'h00 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

>>> src/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: CSRs, window fill count,
// row of wbps_cell instances and the result register. Depends on wbps_pkg.
//
//   channel  dir  transfer on             payload
//   req      in   req_tvalid&req_tready   tdata: data_byte, byte_address; tlast: region_end
//   rsp      out  rsp_tvalid&rsp_tready   tdata: match_address
//   csr      in   csr_valid&csr_ready     csr_index, csr_data
//
// One byte per cycle while req_tready is high; the whole window compare and
// address subtract settle in the cycle a byte is taken, the result lands
// in the rsp register. req_tready drops only while a result waits and
// rsp_tready is low. Synchronous reset clears the window, fill count, result
// valid flag and registers (pattern zero, length 1). csr_ready is always high.
module wildcard_byte_pattern_scanner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] data_byte, [55:8] byte_address
   input  logic [wbps_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [47:0] match_address
   output logic [wbps_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wbps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wbps_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int PM = wbps_pkg::PATTERN_MAX;
   localparam int AB = wbps_pkg::ADDRESS_BITS;
   localparam int LB = wbps_pkg::LEN_BITS;

   logic [63:0]          pattern_low_ff, pattern_low_in;
   logic [63:0]          pattern_high_ff, pattern_high_in;
   logic [4:0]           pattern_len_ff, pattern_len_in;
   logic [LB-1:0]        fill_ff, fill_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]        rsp_addr_ff, rsp_addr_in;

   wbps_pkg::pattern_type   pattern;
   wbps_pkg::cell_ctl_type  ctl;
   wbps_pkg::byte_type      cell_byte [PM];
   wbps_pkg::byte_type      cell_feed [PM];
   logic [PM-1:0]           cell_match;
   logic [LB-1:0]           len_used;
   logic [LB-1:0]           fill_next;
   logic                    req_fire;
   logic                    csr_fire;
   logic                    hit;
   wbps_pkg::byte_type      in_byte;
   logic [AB-1:0]           in_addr;

   assign in_byte    = req_tdata[7:0];
   assign in_addr    = req_tdata[8 +: AB];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   always_comb begin
      for (int j = 0; j < PM; j++) begin
         if (j < 8) begin
            pattern[j] = pattern_low_ff[8*(j & 7) +: 8];
         end else begin
            pattern[j] = pattern_high_ff[8*(j & 7) +: 8];
         end
      end
   end

   always_comb begin
      if (pattern_len_ff == 5'd0) begin
         len_used = LB'(1);
      end else if (6'(pattern_len_ff) > 6'(PM)) begin
         len_used = LB'(PM);
      end else begin
         len_used = LB'(pattern_len_ff);
      end
   end

   assign fill_next = (fill_ff == LB'(PM)) ? fill_ff : fill_ff + LB'(1);
   assign hit       = (fill_next >= len_used) && (&cell_match);
   assign ctl.load  = req_fire;
   assign ctl.clear = hit || req_tlast;

   for (genvar i = 0; i < PM; i++) begin : g_cell
      if (i == PM - 1) begin : g_head
         assign cell_feed[i] = in_byte;
      end else begin : g_body
         assign cell_feed[i] = cell_byte[i+1];
      end
      wbps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_index (wbps_pkg::IDX_BITS'(i)),
         .len        (len_used),
         .pattern    (pattern),
         .byte_in    (cell_feed[i]),
         .byte_out   (cell_byte[i]),
         .match_ok   (cell_match[i])
      );
   end

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      pattern_len_in  = pattern_len_ff;
      if (csr_fire) begin
         unique case (csr_index)
            wbps_pkg::REG_PATTERN_LOW:  pattern_low_in  = csr_data;
            wbps_pkg::REG_PATTERN_HIGH: pattern_high_in = csr_data;
            wbps_pkg::REG_PATTERN_LEN:  pattern_len_in  = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         fill_in = ctl.clear ? LB'(0) : fill_next;
         if (hit) begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = in_addr - AB'(len_used - LB'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= 5'd1;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         pattern_len_ff  <= pattern_len_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = wbps_pkg::RSP_DATA_BITS'(rsp_addr_ff);

endmodule

>>> bench/wbps_checker.sv
// Scoreboard for the wildcard byte pattern scanner: tracks the window and CSRs
// from observed transfers and checks every match address. Depends on wbps_pkg.
`timescale 1ns / 100ps

module wbps_checker
   import wbps_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // [7:0] data_byte, [55:8] byte_address
   input  logic [REQ_DATA_BITS-1:0]    req_tdata,
   input  logic                        req_tlast,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [47:0] match_address
   input  logic [RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_data,
   output int                          fail_count,
   output int                          pending
);

   byte_type                  window [PATTERN_MAX];
   int                        fill;
   pattern_type               pattern;
   logic [4:0]                length_reg;
   logic [ADDRESS_BITS-1:0]   match_q [$];
   logic [ADDRESS_BITS-1:0]   expected_addr;

   function automatic bit scan_byte(input byte_type b, input logic [ADDRESS_BITS-1:0] addr,
                                    input logic last, output logic [ADDRESS_BITS-1:0] hit_addr);
      int n;
      int k;
      bit hit;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > PATTERN_MAX) n = PATTERN_MAX;
      for (k = 0; k < PATTERN_MAX - 1; k++) window[k] = window[k + 1];
      window[PATTERN_MAX - 1] = b;
      if (fill < PATTERN_MAX) fill++;
      hit = (fill >= n);
      for (k = 0; k < n; k++) begin
         if (pattern[k] != WILDCARD_BYTE && pattern[k] != window[PATTERN_MAX - n + k]) hit = 0;
      end
      hit_addr = addr - ADDRESS_BITS'(n - 1);
      // a match or a region end empties the window
      if (hit || last) begin
         window = '{default: '0};
         fill = 0;
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         match_q.delete();
         window = '{default: '0};
         fill = 0;
         pattern = '0;
         length_reg = 5'd1;
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (match_q.size() == 0) begin
               $error("match_address: expected no transfer, actual %h",
                      rsp_tdata[ADDRESS_BITS-1:0]);
               fail_count <= fail_count + 1;
            end else begin
               expected_addr = match_q.pop_front();
               if (rsp_tdata[ADDRESS_BITS-1:0] !== expected_addr) begin
                  $error("match_address: expected %h, actual %h", expected_addr,
                         rsp_tdata[ADDRESS_BITS-1:0]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_LOW: begin
                  pattern[7:0] = csr_data;
               end
               REG_PATTERN_HIGH: begin
                  pattern[15:8] = csr_data;
               end
               REG_PATTERN_LEN: begin
                  length_reg = csr_data[4:0];
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (scan_byte(req_tdata[7:0], req_tdata[8 +: ADDRESS_BITS], req_tlast, expected_addr))
               match_q = {match_q, expected_addr};
         end
         pending <= match_q.size();
      end
   end

endmodule

>>> bench/tb_wildcard_byte_pattern_scanner.sv
// Testbench top for the wildcard byte pattern scanner: clock, reset, byte stream,
// CSR writes and response backpressure. Uses wbps_pkg and wbps_checker.
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner;
   import wbps_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS = 800;
   localparam int CALM_AFTER  = 650;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   // [7:0] data_byte, [55:8] byte_address
   logic [REQ_DATA_BITS-1:0]    req_tdata;
   logic                        req_tlast;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   // [47:0] match_address
   logic [RSP_DATA_BITS-1:0]    rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]    csr_data;

   int          fail_count;
   int          pending;
   pattern_type pat;
   int          plen;
   int          sent;
   bit          calm;
   bit          req_gaps;

   wildcard_byte_pattern_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   wbps_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response backpressure in bursts
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [ADDRESS_BITS-1:0] rand_addr();
      if ($urandom_range(0, 5) == 0)
         return {ADDRESS_BITS{1'b1}} - $urandom_range(0, 20);
      return ADDRESS_BITS'({$urandom, $urandom});
   endfunction

   task automatic send_byte(input byte_type b, input logic [ADDRESS_BITS-1:0] addr,
                            input logic last);
      if (req_gaps && !calm && $urandom_range(0, 11) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {addr, b};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      calm = (sent >= CALM_AFTER);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len_val, input bit junk);
      write_reg(REG_PATTERN_LOW, lo);
      write_reg(REG_PATTERN_HIGH, hi);
      write_reg(REG_PATTERN_LEN, {59'd0, len_val});
      if (junk) write_reg(REG_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
      pat = {hi, lo};
      plen = (len_val == 0) ? 1 : (len_val > PATTERN_MAX) ? PATTERN_MAX : len_val;
   endtask

   // stream stopped and all results back before touching the CSRs
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one region: random bytes mixed with pattern copies, some cut short or corrupted
   task automatic send_region();
      byte_type                q [$];
      byte_type                b;
      int                      rlen;
      int                      k;
      logic [ADDRESS_BITS-1:0] addr;
      rlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : $urandom_range(1, 40);
      while (q.size() < rlen) begin
         case ($urandom_range(0, 3))
            0: begin
               q = {q, byte_type'($urandom)};
            end
            1: begin
               q = {q, pat[$urandom_range(0, plen - 1)]};
            end
            default: begin
               for (k = 0; k < plen; k++) begin
                  b = pat[k];
                  if (b == WILDCARD_BYTE) b = byte_type'($urandom);
                  q = {q, b};
               end
               if ($urandom_range(0, 5) == 0) begin
                  k = q.size() - 1 - $urandom_range(0, plen - 1);
                  q[k] = q[k] ^ (8'h01 << $urandom_range(0, 7));
               end
            end
         endcase
      end
      while (q.size() > rlen) void'(q.pop_back());
      addr = rand_addr();
      for (k = 0; k < rlen; k++) send_byte(q[k], addr + k, k == rlen - 1);
   endtask

   initial begin
      pattern_type             p;
      logic [63:0]             lo;
      logic [63:0]             hi;
      logic [4:0]              len_val;
      logic [ADDRESS_BITS-1:0] addr;
      byte_type                b;
      int                      k;
      int                      phase_end;
      int                      waited;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= REG_PATTERN_LOW;
      csr_data <= '0;
      sent = 0;
      calm = 0;
      req_gaps = 1;
      pat = '0;
      plen = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset pattern: one zero byte
      send_byte(8'h00, '0, 1'b0);
      send_byte(8'hFF, {ADDRESS_BITS{1'b1}}, 1'b0);
      send_byte(8'h00, 48'h5, 1'b1);

      // zero length taken as one, wildcard hits anything
      wait_quiet();
      load_pattern(64'h3F, {$urandom, $urandom}, 5'd0, 1'b0);
      send_byte(8'hA5, 48'h1234_5678_9ABC, 1'b1);

      // full length, address wraps, match on region end
      wait_quiet();
      load_pattern(64'h3F00_FF80_0155_AA7E, 64'h0102_0408_1020_403F, 5'd16, 1'b1);
      for (k = 0; k < PATTERN_MAX; k++) begin
         b = (pat[k] == WILDCARD_BYTE) ? byte_type'($urandom) : pat[k];
         send_byte(b, 48'hFFFF_FFFF_FFFA + k, k == PATTERN_MAX - 1);
      end

      // length change with bytes held in the window
      wait_quiet();
      addr = 48'h8000_0000_0010;
      load_pattern(64'h33_2211, 64'h0, 5'd3, 1'b0);
      send_byte(8'h11, addr, 1'b0);
      send_byte(8'h22, addr + 1, 1'b0);
      wait_quiet();
      load_pattern(64'h3322, 64'h0, 5'd2, 1'b0);
      send_byte(8'h33, addr + 2, 1'b1);

      // oversize length clamps to the maximum
      wait_quiet();
      load_pattern({$urandom, $urandom}, {$urandom, $urandom}, 5'd31, 1'b0);
      send_byte(byte_type'($urandom), rand_addr(), 1'b0);
      send_byte(byte_type'($urandom), rand_addr(), 1'b1);

      while (sent < TOTAL_ITEMS) begin
         wait_quiet();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len_val = 5'($urandom_range(1, 4));
            6, 7:             len_val = 5'($urandom_range(5, PATTERN_MAX));
            8:                len_val = 5'($urandom_range(0, 31));
            default:          len_val = 5'(PATTERN_MAX);
         endcase
         for (k = 0; k < PATTERN_MAX; k++) begin
            case ($urandom_range(0, 7))
               0, 1:    p[k] = WILDCARD_BYTE;
               2:       p[k] = 8'h00;
               3:       p[k] = 8'hFF;
               default: p[k] = byte_type'($urandom);
            endcase
         end
         lo = p[7:0];
         hi = p[15:8];
         if ($urandom_range(0, 4) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
         load_pattern(lo, hi, len_val, $urandom_range(0, 3) == 0);
         req_gaps = ($urandom_range(0, 2) != 0);
         phase_end = sent + $urandom_range(60, 110);
         while (sent < phase_end) begin
            if ($urandom_range(0, 7) == 0)
               send_byte(byte_type'($urandom), rand_addr(), 1'($urandom_range(0, 1)));
            else
               send_region();
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending != 0) $error("match_address: %0d expected transfers never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
